### src/gwm_pkg.sv
package gwm_pkg;

  // Field widths of the transaction payloads and configuration registers.
  localparam int IDX_W     = 12;
  localparam int CFG_W     = 7;
  localparam int CMD_W     = 2;
  localparam int SIDE_BITS = 2;
  localparam int WALLS     = 4;
  localparam int CFG_MAX   = (1 << CFG_W) - 1;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

  // Configuration register indexes.
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SET   = 2'd1,
    CMD_READ  = 2'd2
  } gwm_cmd_e;

  typedef enum logic [SIDE_BITS-1:0] {
    SIDE_NORTH = 2'd0,
    SIDE_EAST  = 2'd1,
    SIDE_SOUTH = 2'd2,
    SIDE_WEST  = 2'd3
  } gwm_side_e;

  // Status returned by the column unit.
  typedef struct packed {
    logic             done;
    logic [CFG_W-1:0] rem;
  } gwm_div_rsp_t;

endpackage

### src/gwm_ram.sv
module gwm_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/gwm_colmod.sv
module gwm_colmod
  import gwm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [IDX_W-1:0] dividend_i,
  input  logic [CFG_W-1:0] divisor_i,
  output gwm_div_rsp_t     rsp_o
);

  // Restoring remainder, one dividend bit per cycle, most significant first.
  localparam int STEP_W = $clog2(IDX_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0]  dvd_q, dvd_d;
  logic [CFG_W-1:0]  dvs_q, dvs_d;
  logic [CFG_W-1:0]  rem_q, rem_d;
  logic [CFG_W:0]    trial;

  assign trial = {rem_q, dvd_q[IDX_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = CFG_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = CFG_W'(trial);
      end
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q + STEP_W'(1);
      if (cnt_q == STEP_W'(IDX_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

### src/grid_wall_map_top.sv
// Wall map of a rectangular grid, four wall bits per cell (north, east,
// south, west), held in one synchronous memory with a registered read.
// The command channel (in_valid_i, in_stall_o) carries command_i,
// cell_index_i and side_i; every command transaction gives exactly one
// result transaction on the result channel (out_valid_o, out_stall_i)
// carrying wall_present_o and out_of_range_o.
// The block works on one command at a time. A read goes through ST_RD_A
// and ST_RD_Q; a set wall waits in ST_DIV for the bit-serial column unit,
// then reads and writes back the cell (ST_RD_A, ST_WR_A) and, if a neighbor
// exists, updates it in ST_WR_B; a clear sweeps every cell in use; a command
// that touches no memory goes straight to ST_DONE. The next command is
// accepted the cycle after the result moves into the output register, so a
// result waiting in that register holds off the next command.
// Grid size is set through the configuration channel (cfg_valid_i,
// cfg_ready_o), index 0 for the width and 1 for the height; it must only
// be written while no command is in flight.
// Reset returns the controller to idle and the size to 64 by 64; the map
// contents are undefined until the first clear. If the receiver stalls, the
// result stays in the output register and a finished command waits behind it.
module grid_wall_map_top
  import gwm_pkg::*;
#(
  parameter int MAX_SIDE  = 64,
  parameter int MAX_CELLS = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [IDX_W-1:0]     cell_index_i,
  input  logic [SIDE_BITS-1:0] side_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 wall_present_o,
  output logic                 out_of_range_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int AW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int CNT_W = $clog2(MAX_CELLS + 1);
  localparam int PW    = (CNT_W > 2 * CFG_W) ? CNT_W : 2 * CFG_W;
  localparam int XW    = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
  localparam logic [CFG_W-1:0] SIDE_CAP =
    (MAX_SIDE > CFG_MAX) ? CFG_W'(CFG_MAX) : CFG_W'(MAX_SIDE);

  // Controller states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_RD_A  = 3'd3;
  localparam logic [2:0] ST_RD_Q  = 3'd4;
  localparam logic [2:0] ST_WR_A  = 3'd5;
  localparam logic [2:0] ST_WR_B  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]           state_q, state_d;
  logic [CFG_W-1:0]     cfg_width_q, cfg_height_q;
  logic [CMD_W-1:0]     cmd_q, cmd_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [SIDE_BITS-1:0] side_q, side_d;
  logic [AW-1:0]        clr_cnt_q, clr_cnt_d;
  logic [CFG_W-1:0]     clr_col_q, clr_col_d;
  logic [AW-1:0]        nb_addr_q, nb_addr_d;
  logic [SIDE_BITS-1:0] nb_side_q, nb_side_d;
  logic                 nb_ok_q, nb_ok_d;
  logic                 present_q, present_d;
  logic                 oor_q, oor_d;
  logic                 out_valid_q, out_valid_d;
  logic                 wall_present_q, out_of_range_q;
  logic                 out_load;

  logic [CFG_W-1:0]     w_eff, h_eff;
  logic [2*CFG_W-1:0]   prod;
  logic [PW-1:0]        prod_x;
  logic [CNT_W-1:0]     cells_n;
  logic [XW-1:0]        w_x, n_x, idx_x, in_idx_x, ci_x;
  logic [WALLS-1:0]     clr_walls;
  logic                 clr_last;
  logic                 accept;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WALLS-1:0]     ram_wdata, ram_rdata;

  logic                 div_start;
  gwm_div_rsp_t         div_rsp;

  // Effective grid size: a zero side counts as one, a large one is capped.
  assign w_eff = (cfg_width_q == '0) ? CFG_W'(1) :
                 (cfg_width_q > SIDE_CAP) ? SIDE_CAP : cfg_width_q;
  assign h_eff = (cfg_height_q == '0) ? CFG_W'(1) :
                 (cfg_height_q > SIDE_CAP) ? SIDE_CAP : cfg_height_q;
  assign prod    = {{CFG_W{1'b0}}, w_eff} * {{CFG_W{1'b0}}, h_eff};
  assign prod_x  = PW'(prod);
  assign cells_n = (prod_x > PW'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : CNT_W'(prod_x);

  assign w_x      = XW'(w_eff);
  assign n_x      = XW'(cells_n);
  assign idx_x    = XW'(idx_q);
  assign in_idx_x = XW'(cell_index_i);
  assign ci_x     = XW'(clr_cnt_q);

  // Border walls of the cell that the clear sweep is on.
  always_comb begin
    clr_walls             = '0;
    clr_walls[SIDE_NORTH] = ci_x < w_x;
    clr_walls[SIDE_SOUTH] = (ci_x + w_x) >= n_x;
    clr_walls[SIDE_WEST]  = clr_col_q == '0;
    clr_walls[SIDE_EAST]  = clr_col_q == (w_eff - CFG_W'(1));
  end
  assign clr_last = ci_x == (n_x - XW'(1));

  assign in_stall_o  = state_q != ST_IDLE;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = state_q == ST_IDLE;
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    side_d    = side_q;
    clr_cnt_d = clr_cnt_q;
    clr_col_d = clr_col_q;
    nb_addr_d = nb_addr_q;
    nb_side_d = nb_side_q;
    nb_ok_d   = nb_ok_q;
    present_d = present_q;
    oor_d     = oor_q;
    div_start = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = AW'(idx_q);
    ram_wdata = ram_rdata | (WALLS'(1) << side_q);
    ram_re    = 1'b0;
    ram_raddr = AW'(idx_q);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d     = command_i;
          idx_d     = cell_index_i;
          side_d    = side_i;
          present_d = 1'b0;
          oor_d     = 1'b0;
          clr_cnt_d = '0;
          clr_col_d = '0;
          unique case (command_i)
            CMD_CLEAR: begin
              state_d = ST_CLEAR;
            end
            CMD_SET, CMD_READ: begin
              if (in_idx_x >= n_x) begin
                oor_d   = 1'b1;
                state_d = ST_DONE;
              end else if (command_i == CMD_SET) begin
                div_start = 1'b1;
                state_d   = ST_DIV;
              end else begin
                state_d = ST_RD_A;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = clr_walls;
        clr_cnt_d = clr_cnt_q + AW'(1);
        clr_col_d = (clr_col_q == (w_eff - CFG_W'(1))) ? '0 : clr_col_q + CFG_W'(1);
        if (clr_last) begin
          clr_cnt_d = '0;
          state_d   = ST_DONE;
        end
      end

      ST_DIV: begin
        // The column is known; work out which neighbor shares the wall.
        if (div_rsp.done) begin
          state_d = ST_RD_A;
          unique case (side_q)
            SIDE_NORTH: begin
              nb_ok_d   = idx_x >= w_x;
              nb_addr_d = AW'(idx_x - w_x);
              nb_side_d = SIDE_SOUTH;
            end
            SIDE_EAST: begin
              nb_ok_d   = (div_rsp.rem != (w_eff - CFG_W'(1))) &&
                          ((idx_x + XW'(1)) < n_x);
              nb_addr_d = AW'(idx_x + XW'(1));
              nb_side_d = SIDE_WEST;
            end
            SIDE_SOUTH: begin
              nb_ok_d   = (idx_x + w_x) < n_x;
              nb_addr_d = AW'(idx_x + w_x);
              nb_side_d = SIDE_NORTH;
            end
            SIDE_WEST: begin
              nb_ok_d   = div_rsp.rem != '0;
              nb_addr_d = AW'(idx_x - XW'(1));
              nb_side_d = SIDE_EAST;
            end
          endcase
        end
      end

      ST_RD_A: begin
        ram_re  = 1'b1;
        state_d = (cmd_q == CMD_READ) ? ST_RD_Q : ST_WR_A;
      end

      ST_RD_Q: begin
        present_d = ram_rdata[side_q];
        state_d   = ST_DONE;
      end

      ST_WR_A: begin
        // Write back the cell and, if there is a neighbor, fetch it in the same cycle;
        // the two addresses always differ.
        ram_we = 1'b1;
        if (nb_ok_q) begin
          ram_re    = 1'b1;
          ram_raddr = nb_addr_q;
          state_d   = ST_WR_B;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_WR_B: begin
        ram_we    = 1'b1;
        ram_waddr = nb_addr_q;
        ram_wdata = ram_rdata | (WALLS'(1) << nb_side_q);
        state_d   = ST_DONE;
      end

      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      clr_cnt_q    <= '0;
      cfg_width_q  <= CFG_RESET;
      cfg_height_q <= CFG_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      clr_cnt_q   <= clr_cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_GRID_WIDTH) begin
          cfg_width_q <= cfg_data_i;
        end
        if (cfg_index_i == REG_GRID_HEIGHT) begin
          cfg_height_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    idx_q     <= idx_d;
    side_q    <= side_d;
    clr_col_q <= clr_col_d;
    nb_addr_q <= nb_addr_d;
    nb_side_q <= nb_side_d;
    nb_ok_q   <= nb_ok_d;
    present_q <= present_d;
    oor_q     <= oor_d;
    if (out_load) begin
      wall_present_q <= present_q;
      out_of_range_q <= oor_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign wall_present_o = wall_present_q;
  assign out_of_range_o = out_of_range_q;

  gwm_colmod u_colmod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cell_index_i),
    .divisor_i  (w_eff),
    .rsp_o      (div_rsp)
  );

  gwm_ram #(
    .WIDTH (WALLS),
    .DEPTH (MAX_CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // An accepted command always leaves idle.
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE)
    else $error("accepted command did not start");

  // A result never reports a wall for an out-of-range cell.
  a_result_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(wall_present_o && out_of_range_o))
    else $error("wall reported for out-of-range cell");

  // The column unit only finishes while the controller waits for it.
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_DIV)
    else $error("column result outside the wait state");

  // Memory writes only come from the clear sweep or a write-back step.
  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR || state_q == ST_WR_A || state_q == ST_WR_B))
    else $error("memory write outside a write state");

endmodule

### bench/gwm_map_checker.sv
module gwm_map_checker
  import gwm_pkg::*;
#(
  parameter int MAX_SIDE  = 64,
  parameter int MAX_CELLS = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [IDX_W-1:0]     cell_index_i,
  input  logic [SIDE_BITS-1:0] side_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic                 wall_present_i,
  input  logic                 out_of_range_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic                 cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam int CW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

  typedef struct packed {
    logic wall_present;
    logic out_of_range;
  } wall_answer_t;

  logic [WALLS-1:0] wall_bits [MAX_CELLS];
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  wall_answer_t     awaited_answers [$];
  wall_answer_t     oldest;
  wall_answer_t     fresh_answer;
  int               mismatches;

  // A size of zero acts as one, anything above the largest side is clamped.
  function automatic int unsigned used_side(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return 32'(v);
  endfunction

  function automatic void set_wall(int unsigned cell_no, gwm_side_e s);
    if (cell_no < MAX_CELLS) wall_bits[CW'(cell_no)][s] = 1'b1;
  endfunction

  function automatic wall_answer_t run_command(logic [CMD_W-1:0] cmd,
                                               logic [IDX_W-1:0] cell_no,
                                               gwm_side_e sd);
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned col;
    logic [WALLS-1:0] walls;
    wall_answer_t ans;
    w = used_side(width_reg);
    h = used_side(height_reg);
    n = w * h;
    if (n > MAX_CELLS) n = MAX_CELLS;
    ans = '0;
    col = cell_no % w;
    case (cmd)
      CMD_CLEAR: begin
        for (int unsigned c = 0; c < n; c++) begin
          walls = '0;
          walls[SIDE_NORTH] = (c < w);
          walls[SIDE_SOUTH] = (c + w >= n);
          walls[SIDE_WEST]  = (c % w == 0);
          walls[SIDE_EAST]  = (c % w == w - 1);
          wall_bits[CW'(c)] = walls;
        end
      end
      CMD_SET, CMD_READ: begin
        if (cell_no >= n) begin
          ans.out_of_range = 1'b1;
        end else if (cmd == CMD_READ) begin
          ans.wall_present = wall_bits[CW'(cell_no)][sd];
        end else begin
          set_wall(32'(cell_no), sd);
          // The facing wall of the neighbour is marked only if it exists.
          case (sd)
            SIDE_NORTH: if (cell_no >= w) set_wall(cell_no - w, SIDE_SOUTH);
            SIDE_EAST:  if (col != w - 1 && cell_no + 1 < n) set_wall(cell_no + 1, SIDE_WEST);
            SIDE_SOUTH: if (cell_no + w < n) set_wall(cell_no + w, SIDE_NORTH);
            default:    if (col != 0) set_wall(cell_no - 1, SIDE_EAST);
          endcase
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = CFG_RESET;
      height_reg = CFG_RESET;
      for (int c = 0; c < MAX_CELLS; c++) wall_bits[CW'(c)] = '0;
      awaited_answers.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_GRID_WIDTH) width_reg = cfg_data_i;
        else height_reg = cfg_data_i;
      end
      // A result leaving this edge belongs to an older command, so pop first.
      if (out_valid_i && !out_stall_i) begin
        if (awaited_answers.size() == 0) begin
          $error("result transaction with nothing awaited: wall_present %0b out_of_range %0b",
                 wall_present_i, out_of_range_i);
          mismatches++;
        end else begin
          oldest = awaited_answers.pop_front();
          if (wall_present_i !== oldest.wall_present) begin
            $error("wall_present: expected %0b, got %0b", oldest.wall_present, wall_present_i);
            mismatches++;
          end
          if (out_of_range_i !== oldest.out_of_range) begin
            $error("out_of_range: expected %0b, got %0b", oldest.out_of_range, out_of_range_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        fresh_answer = run_command(command_i, cell_index_i, gwm_side_e'(side_i));
        awaited_answers.push_back(fresh_answer);
      end
    end
    fail_count_o = mismatches;
    pending_o    = awaited_answers.size();
  end

endmodule

### bench/tb_grid_wall_map_top.sv
// Testbench top for the grid wall map. This module only makes stimulus and
// gives the verdict; the checker beside the block predicts every result
// transaction and compares it.
module tb_grid_wall_map_top;
  import gwm_pkg::*;

  localparam int MAX_SIDE      = 64;
  localparam int MAX_CELLS     = 4096;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int NUM_PHASES    = 12;
  localparam int PH_W          = $clog2(NUM_PHASES);
  localparam int HOLD_PHASE    = 8;
  localparam int PAUSE_PHASE   = 9;
  localparam int CLEAR_CAP     = 256;

  // The command field has one code the block does not define.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                 clk_i;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     command    = CMD_CLEAR;
  logic [IDX_W-1:0]     cell_index = '0;
  logic [SIDE_BITS-1:0] side       = SIDE_NORTH;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic                 wall_present;
  logic                 out_of_range;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_index  = REG_GRID_WIDTH;
  logic [CFG_W-1:0]     cfg_data   = '0;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int tx_idle_pct = 35;
  int rx_idle_pct = 80;
  int hold_asked  = 0;
  int hold_seen   = 0;
  int hold_left   = 0;

  // Grid sizes as written to the registers, including zero and values above
  // the largest side, which the block must clamp. Item counts per setting.
  int unsigned size_w [NUM_PHASES] = '{7, 0, 100, 127, 3, 13, 64, 1, 9, 2, 64, 4};
  int unsigned size_h [NUM_PHASES] = '{3, 9, 100, 2, 3, 127, 1, 0, 6, 64, 64, 5};
  int          n_items[NUM_PHASES] = '{50, 40, 45, 45, 45, 45, 45, 40, 45, 45, 45, 40};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  grid_wall_map_top #(
    .MAX_SIDE (MAX_SIDE),
    .MAX_CELLS(MAX_CELLS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .command_i     (command),
    .cell_index_i  (cell_index),
    .side_i        (side),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .wall_present_o(wall_present),
    .out_of_range_o(out_of_range),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  gwm_map_checker #(
    .MAX_SIDE (MAX_SIDE),
    .MAX_CELLS(MAX_CELLS)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .command_i     (command),
    .cell_index_i  (cell_index),
    .side_i        (side),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .wall_present_i(wall_present),
    .out_of_range_i(out_of_range),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // The result side runs in its own process. It stalls at random, and when
  // the stimulus asks for it, it holds off for a long stretch so that the
  // block fills up and has to stall its command channel.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offers one command transaction, with random idle cycles in front of it.
  // It is entered and left at a falling edge; valid stays high when the next
  // transaction follows without a gap.
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] cell_no,
                       input logic [SIDE_BITS-1:0] sd);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    cell_index <= cell_no;
    side       <= sd;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  // Stops offering commands until every awaited result has been taken, then
  // lets the block settle. Size registers may only change after this.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // One register write; the caller lowers the valid after the last one.
  task automatic write_size(input logic idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
  endtask

  // A new size always starts with a clear, so that no cell that has never
  // been written can be read or updated afterwards.
  task automatic resize(input int unsigned w, input int unsigned h);
    drain();
    write_size(REG_GRID_WIDTH, CFG_W'(w));
    write_size(REG_GRID_HEIGHT, CFG_W'(h));
    cfg_valid <= 1'b0;
    issue(CMD_CLEAR, '0, SIDE_NORTH);
  endtask

  initial begin
    int unsigned w_used;
    int unsigned h_used;
    int unsigned cells_now;
    int unsigned pick;
    logic [IDX_W-1:0] cell_no;
    logic [SIDE_BITS-1:0] sd;
    logic [PH_W-1:0] ph;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // Directed part on a 5 by 4 grid: border walls after a clear, each side
    // of set wall with and without a neighbour, indexes past the grid, the
    // unused command, and a clear that must ignore its index and side.
    resize(5, 4);
    issue(CMD_READ, 0, SIDE_NORTH);
    issue(CMD_READ, 0, SIDE_WEST);
    issue(CMD_READ, 4, SIDE_EAST);
    issue(CMD_READ, 19, SIDE_SOUTH);
    issue(CMD_READ, 19, SIDE_EAST);
    issue(CMD_READ, 6, SIDE_NORTH);
    issue(CMD_SET, 6, SIDE_NORTH);
    issue(CMD_READ, 1, SIDE_SOUTH);
    issue(CMD_SET, 7, SIDE_EAST);
    issue(CMD_READ, 8, SIDE_WEST);
    issue(CMD_SET, 12, SIDE_SOUTH);
    issue(CMD_READ, 17, SIDE_NORTH);
    issue(CMD_SET, 11, SIDE_WEST);
    issue(CMD_READ, 10, SIDE_EAST);
    // Sides on the border, where no neighbour exists.
    issue(CMD_SET, 5, SIDE_WEST);
    issue(CMD_SET, 3, SIDE_NORTH);
    issue(CMD_SET, 17, SIDE_SOUTH);
    issue(CMD_SET, 9, SIDE_EAST);
    issue(CMD_READ, 10, SIDE_WEST);
    issue(CMD_SET, 20, SIDE_EAST);
    issue(CMD_READ, 4095, SIDE_WEST);
    issue(CMD_SET, 4095, SIDE_WEST);
    issue(CMD_UNUSED, 4095, SIDE_WEST);
    issue(CMD_CLEAR, 4095, SIDE_WEST);
    issue(CMD_READ, 6, SIDE_NORTH);

    // Random part, one grid size per phase. The first third has a slow
    // sender against a very slow receiver, the second third the other way
    // round, and the last third runs without random idling.
    for (int p = 0; p < NUM_PHASES; p++) begin
      ph = PH_W'(p);
      if (p < 4) begin
        tx_idle_pct = 35;
        rx_idle_pct = 80;
      end else if (p < 8) begin
        tx_idle_pct = 80;
        rx_idle_pct = 35;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      resize(size_w[ph], size_h[ph]);
      w_used = (size_w[ph] == 0) ? 1 : (size_w[ph] > MAX_SIDE) ? MAX_SIDE : size_w[ph];
      h_used = (size_h[ph] == 0) ? 1 : (size_h[ph] > MAX_SIDE) ? MAX_SIDE : size_h[ph];
      cells_now = w_used * h_used;
      if (cells_now > MAX_CELLS) cells_now = MAX_CELLS;

      for (int k = 0; k < n_items[ph]; k++) begin
        if (p == HOLD_PHASE && k == 5) hold_asked++;
        if (p == PAUSE_PHASE && k == 20) drain();
        pick = $urandom_range(99);
        sd   = SIDE_BITS'($urandom_range(3));
        // Mostly in-range sets and reads so the map builds up real walls.
        if (pick < 45) begin
          issue(CMD_SET, IDX_W'($urandom_range(cells_now - 1)), sd);
        end else if (pick < 85) begin
          issue(CMD_READ, IDX_W'($urandom_range(cells_now - 1)), sd);
        end else if (pick < 93) begin
          if (cells_now < MAX_CELLS) begin
            cell_no = IDX_W'($urandom_range(MAX_CELLS - 1, cells_now));
          end else begin
            cell_no = IDX_W'($urandom_range(MAX_CELLS - 1));
          end
          issue(pick[0] ? CMD_SET : CMD_READ, cell_no, sd);
        end else if (pick < 96) begin
          issue(CMD_UNUSED, IDX_W'($urandom_range(MAX_CELLS - 1)), sd);
        end else if (cells_now <= CLEAR_CAP) begin
          // Clears walk every cell, so they are only repeated on small grids.
          issue(CMD_CLEAR, IDX_W'($urandom_range(MAX_CELLS - 1)), sd);
        end else begin
          issue(CMD_READ, IDX_W'($urandom_range(cells_now - 1)), sd);
        end
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
src/gwm_pkg.sv
src/gwm_ram.sv
src/gwm_colmod.sv
src/grid_wall_map_top.sv
bench/gwm_map_checker.sv
bench/tb_grid_wall_map_top.sv
